FILE: design/mov_pkg.sv
`default_nettype none

package mov_pkg;

    // Field and register widths fixed by the interface.
    localparam int VEL_W     = 32;
    localparam int CFG16_W   = 16;
    localparam int SIZE_W    = 18;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_RADIUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_SUM      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_REV = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GEAR_RATIO    = 2'd3;

    localparam logic [CFG16_W-1:0] WHEEL_RADIUS_RST  = 16'd6554;
    localparam logic [SIZE_W-1:0]  SIZE_SUM_RST      = 18'd26214;
    localparam logic [CFG16_W-1:0] TICKS_PER_REV_RST = 16'd1024;
    localparam logic [CFG16_W-1:0] GEAR_RATIO_RST    = 16'd1280;

    // 15625 * pi in Q16.30. The factor 2^13 of 128000000 is taken out of the
    // 2^30 of the divisor, which leaves a shift of 17 (linear) or 1 (yaw,
    // where the 2^16 of the numerator is taken out as well).
    localparam int K_SCALE_W = 46;
    localparam logic [K_SCALE_W-1:0] K_SCALE = 46'd52707178531250;
    localparam int K_W       = K_SCALE_W + CFG16_W;
    localparam int LIN_SHIFT = 17;
    localparam int YAW_SHIFT = 1;

    // Quotient bits kept by the divider; anything larger saturates.
    localparam int Q_W = 33;
    localparam logic [Q_W-1:0] VEL_LIM_POS = 33'h0_7FFF_FFFF;
    localparam logic [Q_W-1:0] VEL_LIM_NEG = 33'h0_8000_0000;

    // Velocity slots.
    localparam logic [1:0] VEL_X   = 2'd0;
    localparam logic [1:0] VEL_Y   = 2'd1;
    localparam logic [1:0] VEL_YAW = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL_K,
        ST_MUL_T,
        ST_MUL_G,
        ST_MUL_L,
        ST_MUL_N,
        ST_DIV_CHK,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [CFG16_W-1:0] wheel_radius;
        logic [SIZE_W-1:0]  size_sum;
        logic [CFG16_W-1:0] ticks_per_rev;
        logic [CFG16_W-1:0] gear_ratio;
    } t_cfg;

    typedef struct packed {
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] yaw_rate;
        logic                    no_previous;
        logic                    zero_interval;
        logic                    saturated;
    } t_result;

endpackage

`default_nettype wire

FILE: design/mov_core.sv
`default_nettype none

module mov_core
    import mov_pkg::*;
#(
    parameter int TICK_WIDTH = 32,
    parameter int TIME_WIDTH = 48
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_first,
    input  logic                       i_zero_dt,
    input  logic [3:0][TICK_WIDTH-1:0] i_delta,
    input  logic [TIME_WIDTH-1:0]      i_dt,
    input  t_cfg                       i_cfg,
    input  logic                       i_take,
    output logic                       o_busy,
    output logic                       o_done,
    output t_result                    o_result
);

    localparam int MW     = TICK_WIDTH + 2;
    localparam int NW     = MW + K_W;
    localparam int DTG_W  = TIME_WIDTH + 2 * CFG16_W;
    localparam int DTGL_W = DTG_W + SIZE_W;
    localparam int PW     = (NW > DTGL_W) ? NW : DTGL_W;
    localparam int DLW    = (DTG_W + LIN_SHIFT > DTGL_W + YAW_SHIFT) ?
                            DTG_W + LIN_SHIFT : DTGL_W + YAW_SHIFT;
    localparam int DSW    = DLW + Q_W - 1;
    localparam int CW     = (NW > DSW + 1) ? NW : DSW + 1;
    localparam int CNTW   = ($clog2(MW) > $clog2(Q_W)) ? $clog2(MW) : $clog2(Q_W);

    t_state r_state, n_state;

    logic [3:0][TICK_WIDTH-1:0] r_delta, n_delta;
    logic [TIME_WIDTH-1:0]      r_dt, n_dt;
    logic signed [MW-1:0]       r_sum [3];
    logic signed [MW-1:0]       n_sum [3];
    logic [K_W-1:0]             r_k, n_k;
    logic [DTG_W-1:0]           r_dtg, n_dtg;
    logic [DTGL_W-1:0]          r_dtgl, n_dtgl;
    logic [PW-1:0]              r_acc, n_acc;
    logic [PW-1:0]              r_mcand, n_mcand;
    logic [MW-1:0]              r_mplier, n_mplier;
    logic [CNTW-1:0]            r_cnt, n_cnt;
    logic [1:0]                 r_idx, n_idx;
    logic [CW-1:0]              r_rem, n_rem;
    logic [CW-1:0]              r_ds, n_ds;
    logic [Q_W-1:0]             r_quo, n_quo;
    logic                       r_over, n_over;
    logic                       r_neg, n_neg;
    logic signed [VEL_W-1:0]    r_vel [3];
    logic signed [VEL_W-1:0]    n_vel [3];
    logic                       r_first, n_first;
    logic                       r_zero, n_zero;
    logic                       r_sat, n_sat;

    logic signed [MW-1:0] ext [4];
    logic [PW-1:0]        p_acc;
    logic [CNTW-1:0]      last_cnt;
    logic                 step_last;
    logic [1:0]           load_sel;
    logic signed [MW-1:0] sel_sum;
    logic [MW-1:0]        sel_mag;
    logic [DLW-1:0]       div_base;
    logic                 div_bit;
    logic [Q_W-1:0]       q_fin, q_lim, q_mag, q_neg;
    logic                 vel_sat;
    logic [VEL_W-1:0]     vel_val;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            ext[i] = MW'($signed(r_delta[i]));
        end
    end

    // One multiplier bit is consumed per cycle, least significant first.
    assign p_acc = r_acc + (r_mplier[0] ? r_mcand : '0);

    always_comb begin
        case (r_state)
            ST_MUL_L: last_cnt = CNTW'(SIZE_W - 1);
            ST_MUL_N: last_cnt = CNTW'(MW - 1);
            ST_DIV:   last_cnt = CNTW'(Q_W - 1);
            default:  last_cnt = CNTW'(CFG16_W - 1);
        endcase
    end

    assign step_last = (r_cnt == last_cnt);

    assign load_sel = (r_state == ST_MUL_L || r_idx == VEL_YAW) ? VEL_X : r_idx + 2'd1;
    assign sel_sum  = r_sum[load_sel];
    assign sel_mag  = sel_sum[MW-1] ? MW'(-sel_sum) : MW'(sel_sum);

    assign div_base = (r_idx == VEL_YAW) ? DLW'({r_dtgl, {YAW_SHIFT{1'b0}}})
                                         : DLW'({r_dtg, {LIN_SHIFT{1'b0}}});

    assign div_bit = (r_rem >= r_ds);
    assign q_fin   = {r_quo[Q_W-2:0], div_bit};
    assign q_lim   = r_neg ? VEL_LIM_NEG : VEL_LIM_POS;
    assign vel_sat = r_over || (q_fin > q_lim);
    assign q_mag   = vel_sat ? q_lim : q_fin;
    assign q_neg   = Q_W'(0) - q_mag;
    assign vel_val = r_neg ? q_neg[VEL_W-1:0] : q_mag[VEL_W-1:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = (i_first || i_zero_dt) ? ST_DONE : ST_SUM;
                end
            end
            ST_SUM:   n_state = ST_MUL_K;
            ST_MUL_K: if (step_last) n_state = ST_MUL_T;
            ST_MUL_T: if (step_last) n_state = ST_MUL_G;
            ST_MUL_G: if (step_last) n_state = ST_MUL_L;
            ST_MUL_L: if (step_last) n_state = ST_MUL_N;
            ST_MUL_N: if (step_last) n_state = ST_DIV_CHK;
            ST_DIV_CHK: begin
                if (r_rem != '0) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = (r_idx == VEL_YAW) ? ST_DONE : ST_MUL_N;
                end
            end
            ST_DIV: begin
                if (step_last) begin
                    n_state = (r_idx == VEL_YAW) ? ST_DONE : ST_MUL_N;
                end
            end
            ST_DONE: if (i_take) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_busy = (r_state != ST_IDLE);
        o_done = (r_state == ST_DONE);
        o_result.vel_x         = r_vel[VEL_X];
        o_result.vel_y         = r_vel[VEL_Y];
        o_result.yaw_rate      = r_vel[VEL_YAW];
        o_result.no_previous   = r_first;
        o_result.zero_interval = r_zero;
        o_result.saturated     = r_sat;
    end

    // Datapath.
    always_comb begin
        n_delta  = r_delta;
        n_dt     = r_dt;
        n_sum    = r_sum;
        n_k      = r_k;
        n_dtg    = r_dtg;
        n_dtgl   = r_dtgl;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_rem    = r_rem;
        n_ds     = r_ds;
        n_quo    = r_quo;
        n_over   = r_over;
        n_neg    = r_neg;
        n_vel    = r_vel;
        n_first  = r_first;
        n_zero   = r_zero;
        n_sat    = r_sat;

        if (r_state == ST_MUL_K || r_state == ST_MUL_T || r_state == ST_MUL_G ||
            r_state == ST_MUL_L || r_state == ST_MUL_N) begin
            n_acc    = p_acc;
            n_mcand  = r_mcand << 1;
            n_mplier = r_mplier >> 1;
            n_cnt    = r_cnt + 1'b1;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_delta = i_delta;
                    n_dt    = i_dt;
                    n_first = i_first;
                    n_zero  = i_zero_dt;
                    n_sat   = 1'b0;
                    for (int i = 0; i < 3; i++) begin
                        n_vel[i] = '0;
                    end
                end
            end
            ST_SUM: begin
                n_sum[VEL_X]   = ext[0] + ext[1] + ext[2] + ext[3];
                n_sum[VEL_Y]   = (ext[1] + ext[2]) - (ext[0] + ext[3]);
                n_sum[VEL_YAW] = (ext[1] + ext[3]) - (ext[0] + ext[2]);
                n_acc    = '0;
                n_cnt    = '0;
                n_mcand  = PW'(K_SCALE);
                n_mplier = MW'(i_cfg.wheel_radius);
            end
            ST_MUL_K: begin
                if (step_last) begin
                    n_k      = p_acc[K_W-1:0];
                    n_acc    = '0;
                    n_cnt    = '0;
                    n_mcand  = PW'(r_dt);
                    n_mplier = MW'(i_cfg.ticks_per_rev);
                end
            end
            ST_MUL_T: begin
                if (step_last) begin
                    n_acc    = '0;
                    n_cnt    = '0;
                    n_mcand  = p_acc;
                    n_mplier = MW'(i_cfg.gear_ratio);
                end
            end
            ST_MUL_G: begin
                if (step_last) begin
                    n_dtg    = p_acc[DTG_W-1:0];
                    n_acc    = '0;
                    n_cnt    = '0;
                    n_mcand  = p_acc;
                    n_mplier = MW'(i_cfg.size_sum);
                end
            end
            ST_MUL_L: begin
                if (step_last) begin
                    n_dtgl   = p_acc[DTGL_W-1:0];
                    n_idx    = VEL_X;
                    n_acc    = '0;
                    n_cnt    = '0;
                    n_mcand  = PW'(r_k);
                    n_mplier = sel_mag;
                    n_neg    = sel_sum[MW-1];
                end
            end
            ST_MUL_N: begin
                if (step_last) begin
                    n_rem = CW'(p_acc[NW-1:0]);
                    n_ds  = CW'(div_base) << (Q_W - 1);
                    n_cnt = '0;
                end
            end
            ST_DIV_CHK: begin
                // A quotient of 2^33 or more cannot be reached by the loop.
                n_over = (r_rem >= {r_ds[CW-2:0], 1'b0});
                n_quo  = '0;
                if (r_rem == '0 && r_idx != VEL_YAW) begin
                    n_idx    = r_idx + 2'd1;
                    n_acc    = '0;
                    n_cnt    = '0;
                    n_mcand  = PW'(r_k);
                    n_mplier = sel_mag;
                    n_neg    = sel_sum[MW-1];
                end
            end
            ST_DIV: begin
                n_rem = div_bit ? r_rem - r_ds : r_rem;
                n_quo = q_fin;
                n_ds  = r_ds >> 1;
                n_cnt = r_cnt + 1'b1;
                if (step_last) begin
                    n_vel[r_idx] = vel_val;
                    n_sat        = r_sat | vel_sat;
                    if (r_idx != VEL_YAW) begin
                        n_idx    = r_idx + 2'd1;
                        n_acc    = '0;
                        n_cnt    = '0;
                        n_mcand  = PW'(r_k);
                        n_mplier = sel_mag;
                        n_neg    = sel_sum[MW-1];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_delta  <= n_delta;
        r_dt     <= n_dt;
        r_sum    <= n_sum;
        r_k      <= n_k;
        r_dtg    <= n_dtg;
        r_dtgl   <= n_dtgl;
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_cnt    <= n_cnt;
        r_idx    <= n_idx;
        r_rem    <= n_rem;
        r_ds     <= n_ds;
        r_quo    <= n_quo;
        r_over   <= n_over;
        r_neg    <= n_neg;
        r_vel    <= n_vel;
        r_first  <= n_first;
        r_zero   <= n_zero;
        r_sat    <= n_sat;
    end

    a_skip_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_start && (i_first || i_zero_dt)) |=> (r_state == ST_DONE))
        else $error("first sample or zero interval did not finish at once");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !i_take) |=> (r_state == ST_DONE && $stable(o_result)))
        else $error("finished result changed before it was taken");

    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.no_previous || o_result.zero_interval)) |->
        (o_result.vel_x == 0 && o_result.vel_y == 0 && o_result.yaw_rate == 0 &&
         !o_result.saturated && !(o_result.no_previous && o_result.zero_interval)))
        else $error("flagged result carries nonzero velocity");

    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && !r_over) |-> (r_rem < {r_ds[CW-2:0], 1'b0}))
        else $error("divider remainder out of range");

endmodule

`default_nettype wire

FILE: design/mecanum_odometry_velocity.sv
// Mecanum odometry velocity.
// Input channel (i_in_valid / o_in_ready): one request carries four encoder
// counts and a microsecond timestamp. Output channel (o_out_valid /
// i_out_ready): one result per request with vel_x, vel_y and yaw_rate in
// signed Q16.16 plus three flags. Registers are to be written on the plain port
// (i_cfg_we, i_cfg_index, i_cfg_data) only while the block is idle: the user
// must keep to this, the block itself does not enforce it. One request is
// processed at a time by a bit-serial shift-add multiplier and a restoring
// divider that yields one quotient bit per cycle. A velocity whose numerator
// is zero skips the divider; the first sample after reset and a zero
// interval skip the computation and finish at once. The next request is taken
// as soon as the result has moved to the output register.
// Reset clears the previous counts and time, restores the register defaults
// and empties the output register. When the receiver stalls, the result waits
// in the output register, one more waits inside the core, and o_in_ready
// stays low until the core can hand its result over.
`default_nettype none

module mecanum_odometry_velocity
    import mov_pkg::*;
#(
    parameter int TICK_WIDTH = 32,
    parameter int TIME_WIDTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [31:0]       i_ticks_front_left,
    input  logic signed [31:0]       i_ticks_front_right,
    input  logic signed [31:0]       i_ticks_rear_left,
    input  logic signed [31:0]       i_ticks_rear_right,
    input  logic [47:0]              i_timestamp_us,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [VEL_W-1:0]  o_vel_x,
    output logic signed [VEL_W-1:0]  o_vel_y,
    output logic signed [VEL_W-1:0]  o_yaw_rate,
    output logic                     o_no_previous,
    output logic                     o_zero_interval,
    output logic                     o_saturated,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    t_cfg                       r_cfg;
    logic [TICK_WIDTH-1:0]      r_prev_ticks [4];
    logic [TIME_WIDTH-1:0]      r_prev_time;
    logic                       r_have_prev;
    t_result                    r_out;
    logic                       r_out_valid;

    logic [3:0][TICK_WIDTH-1:0] cur_ticks;
    logic [3:0][TICK_WIDTH-1:0] delta;
    logic [TIME_WIDTH-1:0]      now;
    logic [TIME_WIDTH-1:0]      dt;
    logic                       in_acc;
    logic                       first;
    logic                       zero_dt;
    logic                       core_busy;
    logic                       core_done;
    logic                       core_take;
    t_result                    core_result;

    // Counts are sign-extended (or cut) to the tick width, time zero-extended.
    assign cur_ticks[0] = TICK_WIDTH'(i_ticks_front_left);
    assign cur_ticks[1] = TICK_WIDTH'(i_ticks_front_right);
    assign cur_ticks[2] = TICK_WIDTH'(i_ticks_rear_left);
    assign cur_ticks[3] = TICK_WIDTH'(i_ticks_rear_right);
    assign now          = TIME_WIDTH'(i_timestamp_us);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            delta[i] = cur_ticks[i] - r_prev_ticks[i];
        end
    end

    assign dt      = now - r_prev_time;
    assign first   = !r_have_prev;
    assign zero_dt = r_have_prev && (dt == '0);

    assign o_in_ready = !core_busy;
    assign in_acc     = i_in_valid && o_in_ready;
    assign core_take  = core_done && (!r_out_valid || i_out_ready);

    mov_core #(
        .TICK_WIDTH (TICK_WIDTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_acc),
        .i_first   (first),
        .i_zero_dt (zero_dt),
        .i_delta   (delta),
        .i_dt      (dt),
        .i_cfg     (r_cfg),
        .i_take    (core_take),
        .o_busy    (core_busy),
        .o_done    (core_done),
        .o_result  (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wheel_radius  <= WHEEL_RADIUS_RST;
            r_cfg.size_sum      <= SIZE_SUM_RST;
            r_cfg.ticks_per_rev <= TICKS_PER_REV_RST;
            r_cfg.gear_ratio    <= GEAR_RATIO_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WHEEL_RADIUS:  r_cfg.wheel_radius  <= i_cfg_data[CFG16_W-1:0];
                CFG_SIZE_SUM:      r_cfg.size_sum      <= i_cfg_data[SIZE_W-1:0];
                CFG_TICKS_PER_REV: r_cfg.ticks_per_rev <= i_cfg_data[CFG16_W-1:0];
                CFG_GEAR_RATIO:    r_cfg.gear_ratio    <= i_cfg_data[CFG16_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_prev_ticks[i] <= '0;
            end
            r_prev_time <= '0;
            r_have_prev <= 1'b0;
        end else if (in_acc) begin
            for (int i = 0; i < 4; i++) begin
                r_prev_ticks[i] <= cur_ticks[i];
            end
            r_prev_time <= now;
            r_have_prev <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_take) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_vel_x         = r_out.vel_x;
    assign o_vel_y         = r_out.vel_y;
    assign o_yaw_rate      = r_out.yaw_rate;
    assign o_no_previous   = r_out.no_previous;
    assign o_zero_interval = r_out.zero_interval;
    assign o_saturated     = r_out.saturated;

endmodule

`default_nettype wire
